/* hw/rtl/bad_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bad_pkg
// Shared types, register indexes and helpers of the box average downscaler.
// ----------------------------------------------------------------------------
package bad_pkg;

    localparam int DIM_W   = 13;
    localparam int COUNT_W = 26;
    localparam int SHIFT_W = 5;
    localparam int IDX_W   = 4;

    localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 4'd0;
    localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 4'd1;
    localparam logic [IDX_W-1:0] REG_DST_WIDTH  = 4'd2;
    localparam logic [IDX_W-1:0] REG_DST_HEIGHT = 4'd3;
    localparam logic [IDX_W-1:0] REG_FORMAT     = 4'd4;
    localparam logic [IDX_W-1:0] REG_RED_MASK   = 4'd5;
    localparam logic [IDX_W-1:0] REG_GREEN_MASK = 4'd6;
    localparam logic [IDX_W-1:0] REG_BLUE_MASK  = 4'd7;

    localparam logic FMT_BGR  = 1'b0;
    localparam logic FMT_MASK = 1'b1;

    typedef enum logic [1:0] {
        F_INIT,
        F_LOAD,
        F_IDLE,
        F_RMW
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_DONE
    } back_state_t;

    typedef struct packed {
        logic [31:0]        r_sum;
        logic [31:0]        g_sum;
        logic [31:0]        b_sum;
        logic [COUNT_W-1:0] count;
        logic               fmt;
        logic [SHIFT_W-1:0] r_tz;
        logic [SHIFT_W-1:0] g_tz;
        logic [SHIFT_W-1:0] b_tz;
        logic               row_end;
        logic               frame_end;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [SHIFT_W-1:0] trailing_zeros(input logic [31:0] m);
        logic [SHIFT_W-1:0] n;
        n = '0;
        for (int i = 31; i >= 0; i--) begin
            if (m[i])
            begin
                n = SHIFT_W'(i);
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/box_average_downscale.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// box_average_downscale
// Box-filter downscaler: averages each destination pixel's source footprint.
// ----------------------------------------------------------------------------
// Source pixels enter in raster order on in_valid/in_ready/src_pixel. One
// destination pixel leaves on out_valid/out_ready with out_pixel, row_end and
// frame_end when the last source pixel of its box has arrived.
// Registers are written on cfg_valid/cfg_ready with cfg_index and cfg_data;
// a write to any defined register restarts the frame and recomputes the
// span steps, during which no pixel is taken. Reset does the same with the
// default geometry.
// The input takes no new pixel while the column sum of the last one is read
// from the single-port memory and written back. A finished box is queued
// (2 entries), divided by its pixel count and put in the output register;
// boxes closing faster than the divider clears them fill the queue and
// hold off input. When the receiver stalls, the result waits in the output
// register while the divider finishes the next box and holds it, and the
// front keeps working until the queue is full.
// Pixels under an unsupported geometry are taken and dropped.
// ----------------------------------------------------------------------------
module box_average_downscale #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [bad_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [31:0]               cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [31:0]               src_pixel,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [31:0]                    out_pixel,
    output logic                           row_end,
    output logic                           frame_end
);
    import bad_pkg::*;

    q_stat_t q_stat;
    job_t    push_job, pop_job;
    logic    push, pop;

    bad_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .src_pixel(src_pixel),
        .q_stat   (q_stat),
        .push     (push),
        .push_job (push_job)
    );

    bad_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_job(push_job),
        .pop     (pop),
        .pop_job (pop_job),
        .stat    (q_stat)
    );

    bad_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .pop_job  (pop_job),
        .pop      (pop),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_pixel(out_pixel),
        .row_end  (row_end),
        .frame_end(frame_end)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_stat.full && !pop))
        else $error("job pushed into a full queue");

    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !in_ready)
        else $error("input ready while job queue is full");

    a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("job popped from an empty queue");
`endif

endmodule
`default_nettype wire

/* hw/rtl/bad_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bad_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
module bad_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

/* hw/rtl/bad_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bad_queue
// Two-entry job queue between the accumulating front and the dividing back.
// ----------------------------------------------------------------------------
module bad_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire bad_pkg::job_t   push_job,
    input  wire logic            pop,
    output bad_pkg::job_t        pop_job,
    output bad_pkg::q_stat_t     stat
);
    import bad_pkg::*;

    job_t       entry_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assign pop_job    = entry_reg[rptr_reg];
    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);

endmodule
`default_nettype wire

/* hw/rtl/bad_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bad_front
// Configuration, raster position tracking, footprint spans and the
// read-modify-write of the column sum line. Finished boxes go to the queue.
// ----------------------------------------------------------------------------
module bad_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [bad_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [31:0]               cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [31:0]               src_pixel,
    input  wire bad_pkg::q_stat_t          q_stat,
    output logic                           push,
    output bad_pkg::job_t                  push_job
);
    import bad_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    front_state_t state_reg, state_next;

    logic [DIM_W-1:0]   src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    logic               fmt_reg;
    logic [31:0]        rmask_reg, gmask_reg, bmask_reg;
    logic [SHIFT_W-1:0] rtz_reg, gtz_reg, btz_reg;

    logic [DIM_W-1:0] sc_reg, sr_reg, tc_reg, tr_reg;
    logic [DIM_W-1:0] sc_next, sr_next, tc_next, tr_next;
    logic [DIM_W-1:0] cs_reg, ce_reg, rs_reg, re_reg, cerr_reg, rerr_reg;
    logic [DIM_W-1:0] cs_next, ce_next, rs_next, re_next, cerr_next, rerr_next;
    logic [DIM_W-1:0] qc_reg, rc_reg, qr_reg, rr_reg;

    logic [DIM_W-1:0] dwq_reg, dwr_reg, dhq_reg, dhr_reg;
    logic [DIM_W-1:0] dwq_next, dwr_next, dhq_next, dhr_next;
    logic [3:0]       dcnt_reg;

    logic [31:0] pr_reg, pg_reg, pb_reg;
    logic [31:0] pr_in, pg_in, pb_in;

    logic [95:0] ram_rdata, ram_wdata;
    logic [31:0] sum_r, sum_g, sum_b;
    logic        first, emit, geom_ok, accept, cfg_hit;
    logic [DIM_W-1:0]   span_c, span_r;
    logic [COUNT_W-1:0] prod;
    logic [DIM_W:0]     e2;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == F_IDLE) && !q_stat.full;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        cfg_hit = 1'b0;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_DST_WIDTH, REG_DST_HEIGHT,
                REG_FORMAT, REG_RED_MASK, REG_GREEN_MASK, REG_BLUE_MASK: cfg_hit = 1'b1;
                default: cfg_hit = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        geom_ok = (src_w_reg != '0) && (src_h_reg != '0) && (dst_w_reg != '0) &&
                  (dst_h_reg != '0) &&
                  ({19'd0, src_w_reg} <= 32'(MAX_WIDTH)) &&
                  ({19'd0, src_h_reg} <= 32'(MAX_HEIGHT)) &&
                  (dst_w_reg <= src_w_reg) && (dst_h_reg <= src_h_reg);
    end

    always_comb
    begin
        if (fmt_reg == FMT_BGR)
        begin
            pr_in = {24'd0, src_pixel[23:16]};
            pg_in = {24'd0, src_pixel[15:8]};
            pb_in = {24'd0, src_pixel[7:0]};
        end
        else
        begin
            pr_in = (src_pixel & rmask_reg) >> rtz_reg;
            pg_in = (src_pixel & gmask_reg) >> gtz_reg;
            pb_in = (src_pixel & bmask_reg) >> btz_reg;
        end
    end

    bad_ram #(
        .WIDTH(96),
        .DEPTH(MAX_WIDTH)
    ) u_sums (
        .clk  (clk),
        .we   (state_reg == F_RMW),
        .addr (AW'(tc_reg)),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        first = (sc_reg == cs_reg) && (sr_reg == rs_reg);
        sum_r = first ? pr_reg : ram_rdata[95:64] + pr_reg;
        sum_g = first ? pg_reg : ram_rdata[63:32] + pg_reg;
        sum_b = first ? pb_reg : ram_rdata[31:0]  + pb_reg;
        ram_wdata = {sum_r, sum_g, sum_b};
        emit   = (DIM_W'(sc_reg + 1'b1) == ce_reg) && (DIM_W'(sr_reg + 1'b1) == re_reg);
        span_c = ce_reg - cs_reg;
        span_r = re_reg - rs_reg;
        prod   = span_c * span_r;
        push   = (state_reg == F_RMW) && emit;
        push_job.r_sum     = sum_r;
        push_job.g_sum     = sum_g;
        push_job.b_sum     = sum_b;
        push_job.count     = (prod == '0) ? COUNT_W'(1) : prod;
        push_job.fmt       = fmt_reg;
        push_job.r_tz      = rtz_reg;
        push_job.g_tz      = gtz_reg;
        push_job.b_tz      = btz_reg;
        push_job.row_end   = (DIM_W'(tc_reg + 1'b1) == dst_w_reg);
        push_job.frame_end = push_job.row_end && (DIM_W'(tr_reg + 1'b1) == dst_h_reg);
    end

    // restoring divide of source by destination size, one bit a cycle
    always_comb
    begin
        logic [DIM_W:0] tw, th;
        tw = {dwr_reg, dwq_reg[DIM_W-1]};
        th = {dhr_reg, dhq_reg[DIM_W-1]};
        dwq_next = {dwq_reg[DIM_W-2:0], 1'b0};
        dhq_next = {dhq_reg[DIM_W-2:0], 1'b0};
        if (tw >= {1'b0, dst_w_reg})
        begin
            dwr_next    = DIM_W'(tw - {1'b0, dst_w_reg});
            dwq_next[0] = 1'b1;
        end
        else
        begin
            dwr_next = DIM_W'(tw);
        end
        if (th >= {1'b0, dst_h_reg})
        begin
            dhr_next    = DIM_W'(th - {1'b0, dst_h_reg});
            dhq_next[0] = 1'b1;
        end
        else
        begin
            dhr_next = DIM_W'(th);
        end
    end

    // raster advance with incremental span boundaries
    always_comb
    begin
        sc_next = sc_reg; sr_next = sr_reg; tc_next = tc_reg; tr_next = tr_reg;
        cs_next = cs_reg; ce_next = ce_reg; cerr_next = cerr_reg;
        rs_next = rs_reg; re_next = re_reg; rerr_next = rerr_reg;
        e2 = '0;
        sc_next = DIM_W'(sc_reg + 1'b1);
        if (sc_next >= ce_reg)
        begin
            tc_next = DIM_W'(tc_reg + 1'b1);
            if (tc_next >= dst_w_reg)
            begin
                tc_next = '0;
                sc_next = '0;
                sr_next = DIM_W'(sr_reg + 1'b1);
                if (sr_next >= re_reg)
                begin
                    tr_next = DIM_W'(tr_reg + 1'b1);
                    if (tr_next >= dst_h_reg)
                    begin
                        tr_next   = '0;
                        sr_next   = '0;
                        rs_next   = '0;
                        re_next   = qr_reg;
                        rerr_next = rr_reg;
                    end
                    else
                    begin
                        rs_next = re_reg;
                        e2 = {1'b0, rerr_reg} + {1'b0, rr_reg};
                        if (e2 >= {1'b0, dst_h_reg})
                        begin
                            re_next   = DIM_W'(re_reg + qr_reg + 1'b1);
                            rerr_next = DIM_W'(e2 - {1'b0, dst_h_reg});
                        end
                        else
                        begin
                            re_next   = DIM_W'(re_reg + qr_reg);
                            rerr_next = DIM_W'(e2);
                        end
                    end
                end
                cs_next   = '0;
                ce_next   = qc_reg;
                cerr_next = rc_reg;
            end
            else
            begin
                cs_next = ce_reg;
                e2 = {1'b0, cerr_reg} + {1'b0, rc_reg};
                if (e2 >= {1'b0, dst_w_reg})
                begin
                    ce_next   = DIM_W'(ce_reg + qc_reg + 1'b1);
                    cerr_next = DIM_W'(e2 - {1'b0, dst_w_reg});
                end
                else
                begin
                    ce_next   = DIM_W'(ce_reg + qc_reg);
                    cerr_next = DIM_W'(e2);
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_INIT: if (dcnt_reg == 4'(DIM_W - 1)) state_next = F_LOAD;
            F_LOAD: state_next = F_IDLE;
            F_IDLE: if (accept && geom_ok) state_next = F_RMW;
            F_RMW:  state_next = F_IDLE;
            default: state_next = F_INIT;
        endcase
        if (cfg_hit)
        begin
            state_next = F_INIT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pr_reg <= pr_in;
            pg_reg <= pg_in;
            pb_reg <= pb_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_INIT;
            src_w_reg <= 13'd640;
            src_h_reg <= 13'd480;
            dst_w_reg <= 13'd320;
            dst_h_reg <= 13'd240;
            fmt_reg   <= FMT_BGR;
            rmask_reg <= 32'h00FF_0000;
            gmask_reg <= 32'h0000_FF00;
            bmask_reg <= 32'h0000_00FF;
            rtz_reg   <= 5'd16;
            gtz_reg   <= 5'd8;
            btz_reg   <= 5'd0;
            sc_reg <= '0; sr_reg <= '0; tc_reg <= '0; tr_reg <= '0;
            cs_reg <= '0; ce_reg <= '0; cerr_reg <= '0;
            rs_reg <= '0; re_reg <= '0; rerr_reg <= '0;
            qc_reg <= '0; rc_reg <= '0; qr_reg <= '0; rr_reg <= '0;
            dwq_reg <= 13'd640; dwr_reg <= '0;
            dhq_reg <= 13'd480; dhr_reg <= '0;
            dcnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_hit)
            begin
                logic [DIM_W-1:0] nsw, nsh;
                nsw = src_w_reg;
                nsh = src_h_reg;
                case (cfg_index)
                    REG_SRC_WIDTH:  begin src_w_reg <= cfg_data[12:0]; nsw = cfg_data[12:0]; end
                    REG_SRC_HEIGHT: begin src_h_reg <= cfg_data[12:0]; nsh = cfg_data[12:0]; end
                    REG_DST_WIDTH:  dst_w_reg <= cfg_data[12:0];
                    REG_DST_HEIGHT: dst_h_reg <= cfg_data[12:0];
                    REG_FORMAT:     fmt_reg   <= cfg_data[0];
                    REG_RED_MASK:   begin rmask_reg <= cfg_data; rtz_reg <= trailing_zeros(cfg_data); end
                    REG_GREEN_MASK: begin gmask_reg <= cfg_data; gtz_reg <= trailing_zeros(cfg_data); end
                    REG_BLUE_MASK:  begin bmask_reg <= cfg_data; btz_reg <= trailing_zeros(cfg_data); end
                    default: ;
                endcase
                sc_reg <= '0; sr_reg <= '0; tc_reg <= '0; tr_reg <= '0;
                dwq_reg <= nsw; dwr_reg <= '0;
                dhq_reg <= nsh; dhr_reg <= '0;
                dcnt_reg <= '0;
            end
            else
            begin
                case (state_reg)
                    F_INIT:
                    begin
                        dwq_reg  <= dwq_next; dwr_reg <= dwr_next;
                        dhq_reg  <= dhq_next; dhr_reg <= dhr_next;
                        dcnt_reg <= dcnt_reg + 1'b1;
                    end
                    F_LOAD:
                    begin
                        qc_reg <= dwq_reg; rc_reg <= dwr_reg;
                        qr_reg <= dhq_reg; rr_reg <= dhr_reg;
                        cs_reg <= '0; ce_reg <= dwq_reg; cerr_reg <= dwr_reg;
                        rs_reg <= '0; re_reg <= dhq_reg; rerr_reg <= dhr_reg;
                    end
                    F_RMW:
                    begin
                        sc_reg <= sc_next; sr_reg <= sr_next;
                        tc_reg <= tc_next; tr_reg <= tr_next;
                        cs_reg <= cs_next; ce_reg <= ce_next; cerr_reg <= cerr_next;
                        rs_reg <= rs_next; re_reg <= re_next; rerr_reg <= rerr_next;
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/bad_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bad_back
// Per-channel average by a shared-step restoring divider, repacking and the
// output register.
// ----------------------------------------------------------------------------
module bad_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire bad_pkg::q_stat_t q_stat,
    input  wire bad_pkg::job_t pop_job,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [31:0]        out_pixel,
    output logic               row_end,
    output logic               frame_end
);
    import bad_pkg::*;

    back_state_t state_reg, state_next;
    job_t        job_reg;
    logic [31:0]        qr_reg, qg_reg, qb_reg;
    logic [COUNT_W-1:0] rr_reg, rg_reg, rb_reg;
    logic [31:0]        qr_next, qg_next, qb_next;
    logic [COUNT_W-1:0] rr_next, rg_next, rb_next;
    logic [4:0]         cnt_reg;
    logic               out_valid_reg;
    logic [31:0]        pix_reg;
    logic               row_end_reg, frame_end_reg;
    logic               fire;
    logic [31:0]        pix;

    always_comb
    begin
        logic [COUNT_W:0] tr, tg, tb;
        tr = {rr_reg, qr_reg[31]};
        tg = {rg_reg, qg_reg[31]};
        tb = {rb_reg, qb_reg[31]};
        qr_next = {qr_reg[30:0], 1'b0};
        qg_next = {qg_reg[30:0], 1'b0};
        qb_next = {qb_reg[30:0], 1'b0};
        rr_next = COUNT_W'(tr);
        rg_next = COUNT_W'(tg);
        rb_next = COUNT_W'(tb);
        if (tr >= {1'b0, job_reg.count})
        begin
            rr_next = COUNT_W'(tr - {1'b0, job_reg.count});
            qr_next[0] = 1'b1;
        end
        if (tg >= {1'b0, job_reg.count})
        begin
            rg_next = COUNT_W'(tg - {1'b0, job_reg.count});
            qg_next[0] = 1'b1;
        end
        if (tb >= {1'b0, job_reg.count})
        begin
            rb_next = COUNT_W'(tb - {1'b0, job_reg.count});
            qb_next[0] = 1'b1;
        end
    end

    always_comb
    begin
        if (job_reg.fmt == FMT_BGR)
        begin
            pix = {8'd0, qr_reg[7:0], qg_reg[7:0], qb_reg[7:0]};
        end
        else
        begin
            pix = (qr_reg << job_reg.r_tz) | (qg_reg << job_reg.g_tz) |
                  (qb_reg << job_reg.b_tz);
        end
    end

    assign pop  = (state_reg == B_IDLE) && !q_stat.empty;
    assign fire = (state_reg == B_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:  if (pop) state_next = B_DIV;
            B_DIV:   if (cnt_reg == 5'd31) state_next = B_DONE;
            B_DONE:  if (fire) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= pop_job;
            qr_reg  <= pop_job.r_sum;
            qg_reg  <= pop_job.g_sum;
            qb_reg  <= pop_job.b_sum;
            rr_reg  <= '0;
            rg_reg  <= '0;
            rb_reg  <= '0;
        end
        else if (state_reg == B_DIV)
        begin
            qr_reg <= qr_next; qg_reg <= qg_next; qb_reg <= qb_next;
            rr_reg <= rr_next; rg_reg <= rg_next; rb_reg <= rb_next;
        end
        if (fire)
        begin
            pix_reg       <= pix;
            row_end_reg   <= job_reg.row_end;
            frame_end_reg <= job_reg.frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == B_DIV)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = pix_reg;
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;

endmodule
`default_nettype wire
